>>> hdl/i2cmbs_pkg.sv
`default_nettype none

package i2cmbs_pkg;

    // Step length after reset, in ticks
    localparam logic [15:0] TICKS_RESET = 16'd10;

    // Command codes as carried by the func field
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_SEND  = 3'd3,
        CMD_RECV  = 3'd4,
        CMD_SACK  = 3'd5,
        CMD_RACK  = 3'd6
    } t_cmd;

    // Phases of one bit slot: data/clock high, sample, clock low
    localparam logic [1:0] PHASE_LAST = 2'd2;

    // Single-bit mask used when assembling a received byte
    localparam logic [7:0] RX_MSB_MASK = 8'h80;

    // One tick as seen by the sequencer
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic       sda_in;
    } t_tick;

    // One result as produced for each tick
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_in;
    } t_result;

    // Number of pin steps in each command
    function automatic logic [4:0] step_count(input t_cmd cmd);
        logic [4:0] n;
        unique case (cmd)
            CMD_START: n = 5'd4;
            CMD_STOP:  n = 5'd3;
            CMD_SEND:  n = 5'd24;
            CMD_RECV:  n = 5'd25;
            CMD_SACK:  n = 5'd3;
            CMD_RACK:  n = 5'd4;
            default:   n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

>>> hdl/i2cmbs_seq.sv
`default_nettype none

module i2cmbs_seq (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_en,
    input  i2cmbs_pkg::t_tick      i_tick,
    input  wire [15:0]             i_ticks,
    output i2cmbs_pkg::t_result    o_res
);

    localparam logic [1:0] PHASE_LAST_C  = i2cmbs_pkg::PHASE_LAST;
    localparam logic [7:0] RX_MSB_MASK_C = i2cmbs_pkg::RX_MSB_MASK;

    // Sequencer state
    i2cmbs_pkg::t_cmd r_cmd, n_cmd;
    logic [4:0]       r_step, n_step;
    logic [15:0]      r_hold, n_hold;
    logic [1:0]       r_phase, n_phase;
    logic [2:0]       r_bit, n_bit;
    logic [7:0]       r_shift, n_shift;
    logic [7:0]       r_rx, n_rx;
    logic             r_ack, n_ack;
    logic             r_scl, n_scl;
    logic             r_sda, n_sda;

    // Effective state once a new command has been taken
    logic             w_start;
    i2cmbs_pkg::t_cmd e_cmd;
    logic [4:0]       e_step;
    logic [15:0]      e_hold;
    logic [1:0]       e_phase;
    logic [2:0]       e_bit;
    logic [7:0]       e_shift;
    logic             w_busy;
    logic             w_act;
    logic [15:0]      w_len;
    logic [16:0]      w_hold_inc;
    logic             w_adv;
    logic             w_last;
    logic [7:0]       w_shift;
    logic [2:0]       w_bitpos;

    // Take a command only while idle and only for a known code
    assign w_start = (r_cmd == i2cmbs_pkg::CMD_NONE)
                     && (i_tick.func >= i2cmbs_pkg::CMD_START)
                     && (i_tick.func <= i2cmbs_pkg::CMD_RACK);
    assign e_cmd   = w_start ? i2cmbs_pkg::t_cmd'(i_tick.func) : r_cmd;
    assign e_step  = w_start ? 5'd0  : r_step;
    assign e_hold  = w_start ? 16'd0 : r_hold;
    assign e_phase = w_start ? 2'd0  : r_phase;
    assign e_bit   = w_start ? 3'd0  : r_bit;

    always_comb begin
        e_shift = r_shift;
        if (w_start) begin
            priority if (i_tick.func == i2cmbs_pkg::CMD_SEND) begin
                e_shift = i_tick.tx_byte;
            end else if (i_tick.func == i2cmbs_pkg::CMD_SACK) begin
                e_shift = {7'd0, i_tick.ack_out};
            end else begin
                e_shift = 8'd0;
            end
        end
    end

    // Step timing: a step acts on its first tick and lasts w_len ticks
    assign w_busy     = (e_cmd != i2cmbs_pkg::CMD_NONE);
    assign w_act      = w_busy && (e_hold == 16'd0);
    assign w_len      = (i_ticks == 16'd0) ? 16'd1 : i_ticks;
    assign w_hold_inc = {1'b0, e_hold} + 17'd1;
    assign w_adv      = w_busy && (w_hold_inc >= {1'b0, w_len});
    assign w_last     = w_adv
                        && (({1'b0, e_step} + 6'd1) >= {1'b0, i2cmbs_pkg::step_count(e_cmd)});

    // Next command, step, hold and bit-slot position
    always_comb begin
        n_cmd   = e_cmd;
        n_step  = e_step;
        n_hold  = e_hold;
        n_phase = e_phase;
        n_bit   = e_bit;
        if (w_busy) begin
            n_hold = w_hold_inc[15:0];
            if (w_adv) begin
                n_hold = 16'd0;
                n_step = e_step + 5'd1;
                // Receive byte opens with one extra step before its bit slots
                if (!(e_cmd == i2cmbs_pkg::CMD_RECV && e_step == 5'd0)) begin
                    if (e_phase == PHASE_LAST_C) begin
                        n_phase = 2'd0;
                        n_bit   = e_bit + 3'd1;
                    end else begin
                        n_phase = e_phase + 2'd1;
                    end
                end
                if (w_last) begin
                    n_cmd  = i2cmbs_pkg::CMD_NONE;
                    n_step = 5'd0;
                end
            end
        end
    end

    // Bit position within the byte, MSB first
    assign w_bitpos = ~e_bit;

    // Pin levels, shift register and committed receive results
    always_comb begin
        n_scl   = r_scl;
        n_sda   = r_sda;
        w_shift = e_shift;
        if (w_act) begin
            unique case (e_cmd)
                i2cmbs_pkg::CMD_START: begin
                    unique case (e_step)
                        5'd0:    n_sda = 1'b1;
                        5'd1:    n_scl = 1'b1;
                        5'd2:    n_sda = 1'b0;
                        default: n_scl = 1'b0;
                    endcase
                end
                i2cmbs_pkg::CMD_STOP: begin
                    unique case (e_step)
                        5'd0:    n_sda = 1'b0;
                        5'd1:    n_scl = 1'b1;
                        default: n_sda = 1'b1;
                    endcase
                end
                i2cmbs_pkg::CMD_SEND: begin
                    unique case (e_phase)
                        2'd0:    n_sda = e_shift[w_bitpos];
                        2'd1:    n_scl = 1'b1;
                        default: n_scl = 1'b0;
                    endcase
                end
                i2cmbs_pkg::CMD_RECV: begin
                    if (e_step == 5'd0) begin
                        n_sda = 1'b1;
                    end else begin
                        unique case (e_phase)
                            2'd0: n_scl = 1'b1;
                            2'd1: begin
                                if (i_tick.sda_in) begin
                                    w_shift = e_shift | (RX_MSB_MASK_C >> e_bit);
                                end
                            end
                            default: n_scl = 1'b0;
                        endcase
                    end
                end
                i2cmbs_pkg::CMD_SACK: begin
                    unique case (e_step)
                        5'd0:    n_sda = e_shift[0];
                        5'd1:    n_scl = 1'b1;
                        default: n_scl = 1'b0;
                    endcase
                end
                i2cmbs_pkg::CMD_RACK: begin
                    unique case (e_step)
                        5'd0:    n_sda = 1'b1;
                        5'd1:    n_scl = 1'b1;
                        5'd2:    w_shift = {7'd0, i_tick.sda_in};
                        default: n_scl = 1'b0;
                    endcase
                end
                default: begin
                end
            endcase
        end
        n_shift = w_shift;
        n_rx    = r_rx;
        n_ack   = r_ack;
        if (w_last && e_cmd == i2cmbs_pkg::CMD_RECV) begin
            n_rx = w_shift;
        end
        if (w_last && e_cmd == i2cmbs_pkg::CMD_RACK) begin
            n_ack = w_shift[0];
        end
    end

    // Result of this tick
    always_comb begin
        o_res.scl_level = n_scl;
        o_res.sda_level = n_sda;
        o_res.busy_res  = w_busy;
        o_res.done_res  = w_last;
        o_res.rx_byte   = n_rx;
        o_res.ack_in    = n_ack;
    end

    // Advance state once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= i2cmbs_pkg::CMD_NONE;
            r_step  <= 5'd0;
            r_hold  <= 16'd0;
            r_phase <= 2'd0;
            r_bit   <= 3'd0;
            r_shift <= 8'd0;
            r_rx    <= 8'd0;
            r_ack   <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
        end else if (i_en) begin
            r_cmd   <= n_cmd;
            r_step  <= n_step;
            r_hold  <= n_hold;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_rx    <= n_rx;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
        end
    end

endmodule

`default_nettype wire

>>> hdl/i2c_master_bit_sequencer.sv
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_ready    i_func, i_tx_byte, i_ack_out, i_sda_in
// out      output     o_out_valid / i_out_ready  o_scl_level, o_sda_level, o_busy_res,
//                                                o_done_res, o_rx_byte, o_ack_in
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_data (ticks per step)
//
// One transaction in gives one transaction out, one per cycle when unstalled.
// A tick is registered, then passes the sequencer logic into the result register.
// Reset (synchronous, active low) idles the sequencer with both lines released.
// A stalled output holds the tick in the input register; input is refused only
// while both registers are full.

module i2c_master_bit_sequencer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [2:0]  i_func,
    input  wire  [7:0]  i_tx_byte,
    input  wire         i_ack_out,
    input  wire         i_sda_in,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_rx_byte,
    output logic        o_ack_in,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [15:0] i_cfg_data
);

    logic                r_in_valid;
    i2cmbs_pkg::t_tick   r_tick;
    logic                r_out_valid;
    i2cmbs_pkg::t_result r_res;
    i2cmbs_pkg::t_result w_res;
    logic [15:0]         r_ticks;
    logic                w_adv;

    // Move a tick on when the result register is free or being emptied
    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    // Hold the step length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= i2cmbs_pkg::TICKS_RESET;
        end else if (i_cfg_valid) begin
            r_ticks <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_tick.func    <= i_func;
            r_tick.tx_byte <= i_tx_byte;
            r_tick.ack_out <= i_ack_out;
            r_tick.sda_in  <= i_sda_in;
        end
    end

    i2cmbs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_tick  (r_tick),
        .i_ticks (r_ticks),
        .o_res   (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_level = r_res.scl_level;
    assign o_sda_level = r_res.sda_level;
    assign o_busy_res  = r_res.busy_res;
    assign o_done_res  = r_res.done_res;
    assign o_rx_byte   = r_res.rx_byte;
    assign o_ack_in    = r_res.ack_in;

    // A draining output never blocks the input
    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |-> o_in_ready)
        else $error("input refused while output drains");

    // A registered tick with an empty result register shows a result next cycle
    a_tick_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> o_out_valid)
        else $error("registered tick not passed to output");

    // Done only ever marks a tick of a running command
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> o_busy_res)
        else $error("done without busy");

endmodule

`default_nettype wire

>>> dv/i2c_master_bit_sequencer_test.sv
`timescale 1ns / 100ps

module i2c_master_bit_sequencer_test;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int RUN_LIMIT     = 2000000;
    localparam int RANDOM_TICKS  = 100;
    localparam int STALL_AT      = 400;
    localparam int STALL_LONG    = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam logic [15:0] STEP_LONG = 16'd20;
    // func value outside the command set
    localparam logic [2:0] FUNC_UNUSED = 3'd7;
    // level of sda_in on the idle ticks that finish a command
    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_RANDOM = 2;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [2:0]  i_func      = '0;
    logic [7:0]  i_tx_byte   = '0;
    logic        i_ack_out   = 1'b0;
    logic        i_sda_in    = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data  = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_scl_level;
    logic        o_sda_level;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_rx_byte;
    logic        o_ack_in;
    logic        o_cfg_ready;

    i2c_master_bit_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_tx_byte   (i_tx_byte),
        .i_ack_out   (i_ack_out),
        .i_sda_in    (i_sda_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_scl_level (o_scl_level),
        .o_sda_level (o_sda_level),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_rx_byte   (o_rx_byte),
        .o_ack_in    (o_ack_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Sequencer state as predicted from the accepted ticks
    i2cmbs_pkg::t_cmd seq_cmd = i2cmbs_pkg::CMD_NONE;
    logic [4:0]  seq_step   = '0;
    logic [15:0] seq_hold   = '0;
    logic [7:0]  seq_shift  = '0;
    logic [7:0]  seq_rx     = '0;
    logic        seq_ack    = 1'b0;
    logic        seq_scl    = 1'b1;
    logic        seq_sda    = 1'b1;
    logic [15:0] step_ticks = i2cmbs_pkg::TICKS_RESET;

    i2cmbs_pkg::t_tick   ticks_pending[$];
    i2cmbs_pkg::t_result bus_states_due[$];
    i2cmbs_pkg::t_tick   drive_tick;
    i2cmbs_pkg::t_result due_state;

    int   burst_left     = 0;
    int   gap_left       = 0;
    int   rx_mode        = 0;
    int   mode_left      = 0;
    int   hold_off       = 0;
    bit   hold_started   = 1'b0;
    bit   steady         = 1'b0;
    int   results_seen   = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;

    // Advance the predicted sequencer by one tick and return the pins it shows
    function automatic i2cmbs_pkg::t_result sequence_tick(input i2cmbs_pkg::t_tick tk);
        i2cmbs_pkg::t_result res;
        logic [15:0] len;
        logic [4:0]  n_steps;
        logic [4:0]  slot;
        logic [4:0]  phase;
        res = '0;
        len = (step_ticks == '0) ? 16'd1 : step_ticks;
        // take a command only from idle
        if (seq_cmd == i2cmbs_pkg::CMD_NONE && tk.func >= i2cmbs_pkg::CMD_START
            && tk.func <= i2cmbs_pkg::CMD_RACK) begin
            seq_cmd  = i2cmbs_pkg::t_cmd'(tk.func);
            seq_step = '0;
            seq_hold = '0;
            case (seq_cmd)
                i2cmbs_pkg::CMD_SEND: seq_shift = tk.tx_byte;
                i2cmbs_pkg::CMD_SACK: seq_shift = {7'd0, tk.ack_out};
                default:              seq_shift = '0;
            endcase
        end
        if (seq_cmd != i2cmbs_pkg::CMD_NONE) begin
            res.busy_res = 1'b1;
            // a step takes effect on the first tick of its hold
            if (seq_hold == '0) begin
                slot  = (seq_cmd == i2cmbs_pkg::CMD_RECV) ? seq_step - 5'd1 : seq_step;
                phase = slot % 5'd3;
                case (seq_cmd)
                    i2cmbs_pkg::CMD_START: begin
                        case (seq_step)
                            5'd0:    seq_sda = 1'b1;
                            5'd1:    seq_scl = 1'b1;
                            5'd2:    seq_sda = 1'b0;
                            default: seq_scl = 1'b0;
                        endcase
                    end
                    i2cmbs_pkg::CMD_STOP: begin
                        case (seq_step)
                            5'd0:    seq_sda = 1'b0;
                            5'd1:    seq_scl = 1'b1;
                            default: seq_sda = 1'b1;
                        endcase
                    end
                    i2cmbs_pkg::CMD_SEND: begin
                        if (phase == 5'd0)
                            seq_sda = seq_shift[3'd7 - 3'(slot / 5'd3)];
                        else if (phase == 5'd1)
                            seq_scl = 1'b1;
                        else
                            seq_scl = 1'b0;
                    end
                    i2cmbs_pkg::CMD_RECV: begin
                        if (seq_step == 5'd0) begin
                            seq_sda = 1'b1;
                        end else if (phase == 5'd0) begin
                            seq_scl = 1'b1;
                        end else if (phase == 5'd1) begin
                            if (tk.sda_in)
                                seq_shift = seq_shift
                                            | (i2cmbs_pkg::RX_MSB_MASK >> (slot / 5'd3));
                        end else begin
                            seq_scl = 1'b0;
                        end
                    end
                    i2cmbs_pkg::CMD_SACK: begin
                        case (seq_step)
                            5'd0:    seq_sda = seq_shift[0];
                            5'd1:    seq_scl = 1'b1;
                            default: seq_scl = 1'b0;
                        endcase
                    end
                    i2cmbs_pkg::CMD_RACK: begin
                        case (seq_step)
                            5'd0:    seq_sda = 1'b1;
                            5'd1:    seq_scl = 1'b1;
                            5'd2:    seq_shift = {7'd0, tk.sda_in};
                            default: seq_scl = 1'b0;
                        endcase
                    end
                    default: ;
                endcase
            end
            seq_hold = seq_hold + 16'd1;
            // move to the next step once the hold is over
            if (seq_hold >= len) begin
                seq_hold = '0;
                seq_step = seq_step + 5'd1;
                case (seq_cmd)
                    i2cmbs_pkg::CMD_START: n_steps = 5'd4;
                    i2cmbs_pkg::CMD_STOP:  n_steps = 5'd3;
                    i2cmbs_pkg::CMD_SEND:  n_steps = 5'd24;
                    i2cmbs_pkg::CMD_RECV:  n_steps = 5'd25;
                    i2cmbs_pkg::CMD_SACK:  n_steps = 5'd3;
                    default:               n_steps = 5'd4;
                endcase
                if (seq_step >= n_steps) begin
                    res.done_res = 1'b1;
                    if (seq_cmd == i2cmbs_pkg::CMD_RECV)
                        seq_rx = seq_shift;
                    else if (seq_cmd == i2cmbs_pkg::CMD_RACK)
                        seq_ack = seq_shift[0];
                    seq_cmd  = i2cmbs_pkg::CMD_NONE;
                    seq_step = '0;
                end
            end
        end
        res.scl_level = seq_scl;
        res.sda_level = seq_sda;
        res.rx_byte   = seq_rx;
        res.ack_in    = seq_ack;
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    task automatic push_tick(input logic [2:0] func, input logic [7:0] tx, input logic ack,
                             input logic sda);
        i2cmbs_pkg::t_tick tk;
        tk.func    = func;
        tk.tx_byte = tx;
        tk.ack_out = ack;
        tk.sda_in  = sda;
        ticks_pending.push_back(tk);
    endtask

    // Drain the block, then feed idle ticks until the running command has finished
    task automatic settle(input int sda_mode);
        logic sda_fill;
        int   chunk;
        do begin
            while (ticks_pending.size() != 0 || i_in_valid || bus_states_due.size() != 0)
                @(negedge i_clk);
            chunk = (step_ticks > 16'd100) ? 4096 : 32;
            if (seq_cmd != i2cmbs_pkg::CMD_NONE) begin
                for (int i = 0; i < chunk; i++) begin
                    sda_fill = (sda_mode == SDA_RANDOM) ? 1'($urandom) : 1'(sda_mode);
                    push_tick(i2cmbs_pkg::CMD_NONE, 8'($urandom), 1'($urandom), sda_fill);
                end
            end
        end while (seq_cmd != i2cmbs_pkg::CMD_NONE);
    endtask

    // Write the step length while the block is idle
    task automatic write_step_ticks(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        step_ticks = value;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_phase(input logic [15:0] value);
        logic [2:0] func;
        write_step_ticks(value);
        for (int i = 0; i < RANDOM_TICKS; i++) begin
            if ($urandom_range(0, 9) < 4)
                func = 3'($urandom_range(i2cmbs_pkg::CMD_START, FUNC_UNUSED));
            else
                func = i2cmbs_pkg::CMD_NONE;
            push_tick(func, 8'($urandom), 1'($urandom), 1'($urandom));
        end
        settle(SDA_RANDOM);
    endtask

    // Sender: score each accepted transaction, present ticks in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (i_in_valid && o_in_ready)
                bus_states_due.push_back(sequence_tick(drive_tick));
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (ticks_pending.size() != 0) begin
                    drive_tick = ticks_pending.pop_front();
                    i_func     <= drive_tick.func;
                    i_tx_byte  <= drive_tick.tx_byte;
                    i_ack_out  <= drive_tick.ack_out;
                    i_sda_in   <= drive_tick.sda_in;
                    i_in_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 40);
                        if (steady || $urandom_range(0, 3) == 0)
                            gap_left <= 0;
                        else
                            gap_left <= $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall on a changing pattern, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (!hold_started && results_seen >= STALL_AT) begin
            hold_started <= 1'b1;
            hold_off     <= STALL_LONG;
            i_out_ready  <= 1'b0;
        end else if (hold_off != 0) begin
            hold_off    <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else if (steady) begin
            i_out_ready <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= $urandom_range(0, 3);
                mode_left <= $urandom_range(16, 96);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 3) != 0);
                2:       i_out_ready <= (cycle_count[1:0] != 2'd0);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen <= results_seen + 1;
            if (bus_states_due.size() == 0) begin
                $display("%0t: result with nothing expected, actual %0h", $time,
                         {o_scl_level, o_sda_level, o_busy_res, o_done_res, o_rx_byte,
                          o_ack_in});
                mismatch_count++;
            end else begin
                due_state = bus_states_due.pop_front();
                check_field("scl_level", 8'(due_state.scl_level), 8'(o_scl_level));
                check_field("sda_level", 8'(due_state.sda_level), 8'(o_sda_level));
                check_field("busy_res", 8'(due_state.busy_res), 8'(o_busy_res));
                check_field("done_res", 8'(due_state.done_res), 8'(o_done_res));
                check_field("rx_byte", due_state.rx_byte, o_rx_byte);
                check_field("ack_in", 8'(due_state.ack_in), 8'(o_ack_in));
            end
        end
    end

    // Guard against a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAIL i2c_master_bit_sequencer");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed ticks: a start at the reset step length
        push_tick(i2cmbs_pkg::CMD_NONE, 8'h00, 1'b0, 1'b0);
        push_tick(FUNC_UNUSED, 8'hFF, 1'b1, 1'b1);
        push_tick(i2cmbs_pkg::CMD_START, 8'h5A, 1'b1, 1'b1);
        // lands while the start is running and must be ignored
        push_tick(i2cmbs_pkg::CMD_SEND, 8'hA5, 1'b0, 1'b0);
        settle(SDA_RANDOM);

        // Remaining directed commands at a one-tick step
        write_step_ticks(16'd1);
        push_tick(i2cmbs_pkg::CMD_SEND, 8'hFF, 1'b0, 1'b1);
        settle(SDA_RANDOM);
        push_tick(i2cmbs_pkg::CMD_SEND, 8'h00, 1'b1, 1'b0);
        settle(SDA_RANDOM);
        push_tick(i2cmbs_pkg::CMD_RACK, 8'h00, 1'b1, 1'b0);
        settle(SDA_LOW);
        push_tick(i2cmbs_pkg::CMD_RACK, 8'hFF, 1'b0, 1'b1);
        settle(SDA_HIGH);
        push_tick(i2cmbs_pkg::CMD_RECV, 8'h00, 1'b0, 1'b1);
        settle(SDA_HIGH);
        push_tick(i2cmbs_pkg::CMD_RECV, 8'hFF, 1'b1, 1'b0);
        settle(SDA_LOW);
        push_tick(i2cmbs_pkg::CMD_SACK, 8'hFF, 1'b0, 1'b1);
        settle(SDA_RANDOM);
        push_tick(i2cmbs_pkg::CMD_SACK, 8'h00, 1'b1, 1'b0);
        settle(SDA_RANDOM);
        push_tick(i2cmbs_pkg::CMD_STOP, 8'h3C, 1'b0, 1'b1);
        settle(SDA_RANDOM);

        // Random ticks over several step lengths, zero acting as one
        random_phase(16'd1);
        random_phase(16'd0);
        random_phase(16'd3);

        // Long step length: one short command, run without stalls
        write_step_ticks(STEP_LONG);
        steady = 1'b1;
        push_tick(i2cmbs_pkg::CMD_SACK, 8'h81, 1'b0, 1'b1);
        settle(SDA_RANDOM);
        steady = 1'b0;

        random_phase(16'd2);
        random_phase(16'd1);

        // Let any stray transaction surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bus_states_due.size() != 0)
            $display("%0t: %0d results never arrived", $time, bus_states_due.size());
        if (mismatch_count == 0 && bus_states_due.size() == 0) begin
            $display("PASS i2c_master_bit_sequencer");
        end else begin
            $display("FAIL i2c_master_bit_sequencer");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/i2cmbs_pkg.sv
hdl/i2cmbs_seq.sv
hdl/i2c_master_bit_sequencer.sv
dv/i2c_master_bit_sequencer_test.sv
